// File: rtl/imu_complementary_filter_macros.svh
// assertion macros for the filter rtl, used by icf_back
// expects clk and arst_n in the scope of the module that uses them
`ifndef IMU_COMPLEMENTARY_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_FILTER_MACROS_SVH
// property must hold at every edge out of reset
`define ICF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// condition must never be seen out of reset
`define ICF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`endif

// File: rtl/icf_pkg.sv
// types, constants and the cordic angle table of the imu complementary filter
// no dependencies
package icf_pkg;

	localparam int CW        = 34;  // cordic datapath width
	localparam int AW        = 32;  // q16.16 angle width
	localparam int INC_W     = 27;  // gyro increment width
	localparam int DIV_W     = 32;  // dividend width of the divide by 131

	localparam logic signed [AW-1:0] DEG180_Q16 = 32'sd11796480;
	localparam logic [29:0]          INVK_Q30   = 30'd652032875;
	localparam logic [40:0]          GYRO_RND   = 41'd16768;
	// ceil(2^40 / 131), exact quotient for any 32-bit dividend after a shift by 40
	localparam logic [32:0]          RECIP_131  = 33'd8393218533;
	localparam logic [16:0]          ALPHA_ONE  = 17'd32768;
	localparam logic signed [51:0]   BLEND_RND  = 52'sd16384;
	localparam logic signed [7:0]    CENTI      = 8'sd100;
	localparam logic signed [39:0]   TRUNC_ADJ  = 40'sd65535;

	localparam logic REG_ALPHA = 1'b0;
	localparam logic REG_DT    = 1'b1;

	typedef struct packed {
		logic signed [15:0] gyro_z;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_x;
		logic signed [15:0] accel_z;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_x;
	} sample_t;

	typedef struct packed {
		logic    valid;
		sample_t smp;
	} fe_item_t;

	typedef struct packed {
		logic                 start;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} cordic_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic signed [AW-1:0] z;
		logic signed [CW-1:0] mag;
	} cordic_rsp_t;

	// atan(2^-i) in q16.16 degrees
	function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] idx);
		logic signed [AW-1:0] v;
		case (idx)
			5'd0:  v = 32'sd2949120;
			5'd1:  v = 32'sd1740967;
			5'd2:  v = 32'sd919879;
			5'd3:  v = 32'sd466945;
			5'd4:  v = 32'sd234379;
			5'd5:  v = 32'sd117305;
			5'd6:  v = 32'sd58666;
			5'd7:  v = 32'sd29335;
			5'd8:  v = 32'sd14668;
			5'd9:  v = 32'sd7334;
			5'd10: v = 32'sd3667;
			5'd11: v = 32'sd1833;
			5'd12: v = 32'sd917;
			5'd13: v = 32'sd458;
			5'd14: v = 32'sd229;
			5'd15: v = 32'sd115;
			5'd16: v = 32'sd57;
			5'd17: v = 32'sd29;
			5'd18: v = 32'sd14;
			5'd19: v = 32'sd7;
			5'd20: v = 32'sd4;
			5'd21: v = 32'sd2;
			5'd22: v = 32'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/icf_front.sv
// input side: stream slave, sample unpacking and a two-entry queue
// depends on icf_pkg
module icf_front import icf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	input  logic        pop,
	output fe_item_t    fe
);

	sample_t    q_mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	sample_t    smp_in;
	logic       push;

	always_comb begin
		smp_in.accel_x = s_tdata[15:0];
		smp_in.accel_y = s_tdata[31:16];
		smp_in.accel_z = s_tdata[47:32];
		smp_in.gyro_x  = s_tdata[63:48];
		smp_in.gyro_y  = s_tdata[79:64];
		smp_in.gyro_z  = s_tdata[95:80];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign fe.valid = (cnt_q != 2'd0);
	assign fe.smp   = q_mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q] <= smp_in;
	end

endmodule

// File: rtl/icf_cordic.sv
// iterative cordic in vectoring mode, one micro-rotation per cycle
// depends on icf_pkg for the angle table and request/response types
module icf_cordic import icf_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_req_t req,
	output cordic_rsp_t rsp
);

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [AW-1:0] z_q;
	logic [IW-1:0]        i_q;
	logic                 busy_q, done_q;
	logic                 zero_in;

	assign zero_in = (req.x == '0) && (req.y == '0);
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				i_q    <= '0;
				busy_q <= !zero_in;
				done_q <= zero_in;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (zero_in) begin
				x_q <= '0;
				y_q <= '0;
				z_q <= '0;
			end else if (req.x[CW-1]) begin
				// left half plane: fold over and start at +-180
				x_q <= -req.x;
				y_q <= -req.y;
				z_q <= req.y[CW-1] ? -DEG180_Q16 : DEG180_Q16;
			end else begin
				x_q <= req.x;
				y_q <= req.y;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q16(5'(i_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q16(5'(i_q));
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.z    = z_q;
	assign rsp.mag  = x_q;

endmodule

// File: rtl/icf_back.sv
// execution side: gyro scaling, cordic angles, blend, centidegree output register
// depends on icf_pkg, icf_cordic and the assertion macros
`include "imu_complementary_filter_macros.svh"
module icf_back import icf_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  fe_item_t    fe,
	output logic        pop,
	input  logic [15:0] alpha_q15,
	input  logic [24:0] dt_q24,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // pitch_centideg, roll_centideg, yaw_centideg
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_GMUL  = 4'd1;
	localparam logic [3:0] ST_RGO   = 4'd2;
	localparam logic [3:0] ST_RWAIT = 4'd3;
	localparam logic [3:0] ST_MAG   = 4'd4;
	localparam logic [3:0] ST_PGO   = 4'd5;
	localparam logic [3:0] ST_PWAIT = 4'd6;
	localparam logic [3:0] ST_DWAIT = 4'd7;
	localparam logic [3:0] ST_BL1   = 4'd8;
	localparam logic [3:0] ST_BL2   = 4'd9;
	localparam logic [3:0] ST_BL3   = 4'd10;
	localparam logic [3:0] ST_YAW   = 4'd11;
	localparam logic [3:0] ST_CV1   = 4'd12;
	localparam logic [3:0] ST_CV2   = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	logic [3:0] st_q, st_n;
	logic [1:0] k_q;
	sample_t    smp_q;

	cordic_req_t cq;
	cordic_rsp_t cr;

	// gyro product and a pipelined divide by 131 shared by the x, y and z lanes
	logic signed [40:0]   p_q, p_next, p_abs;
	logic                 p_vld_q;
	logic [1:0]           p_lane_q;
	logic [DIV_W-1:0]     n_load;
	logic [DIV_W-1:0]     n_s1;
	logic                 vld_s1, vld_s2;
	logic                 neg_s1, neg_s2;
	logic [1:0]           lane_s1, lane_s2;
	logic [48:0]          plo_s2, phi_s2;
	logic [64:0]          q_full;
	logic [24:0]          quo_q [3];
	logic                 qneg_q [3];
	logic signed [INC_W-1:0] inc [3];
	logic                 div_busy;
	logic signed [15:0]   g_sel;

	logic [61:0]          mprod_q;
	logic signed [AW-1:0] racc_q, pacc_q;
	logic signed [AW-1:0] pitch_q, roll_q, yaw_q;

	logic [16:0]          a_cl, b_w;
	logic signed [AW-1:0] old_sel, acc_sel, ang_sel;
	logic signed [INC_W-1:0] inc_sel;
	logic signed [32:0]   sum_old;
	logic signed [50:0]   prod1_s1, prod2_s2;
	logic signed [51:0]   s_sum;
	logic signed [36:0]   s_sh;
	logic signed [AW-1:0] blend_sat;
	logic signed [39:0]   cprod_q, c_adj;
	logic signed [23:0]   c_div;
	logic signed [15:0]   c_sat;
	logic signed [15:0]   res_q [3];
	logic                 out_vld_q;
	logic [47:0]          out_q;
	logic                 out_load;

	icf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cq),
		.rsp    (cr)
	);

	assign pop      = (st_q == ST_IDLE) && fe.valid;
	assign out_load = (st_q == ST_OUT) && (!out_vld_q || m_tready);

	// cordic operands: raw values scaled by 2^14; for pitch, x is the gain-corrected magnitude of the roll pass
	always_comb begin
		cq.start = (st_q == ST_RGO) || (st_q == ST_PGO);
		if (st_q == ST_RGO) begin
			cq.x = {{(CW-30){smp_q.accel_z[15]}}, smp_q.accel_z, 14'b0};
			cq.y = {{(CW-30){smp_q.accel_y[15]}}, smp_q.accel_y, 14'b0};
		end else begin
			cq.x = {{(CW-32){1'b0}}, mprod_q[61:30]};
			cq.y = -{{(CW-30){smp_q.accel_x[15]}}, smp_q.accel_x, 14'b0};
		end
	end

	// gyro scaling
	always_comb begin
		case (k_q)
			2'd0:    g_sel = smp_q.gyro_x;
			2'd1:    g_sel = smp_q.gyro_y;
			default: g_sel = smp_q.gyro_z;
		endcase
	end
	assign p_next = g_sel * $signed({1'b0, dt_q24});
	assign p_abs  = p_q[40] ? -p_q : p_q;
	// rounded magnitude over 256 stays below 2^32
	assign n_load = DIV_W'((p_abs + $signed(GYRO_RND)) >>> 8);

	// reciprocal multiply split in two 16-bit halves of the dividend
	assign q_full = {phi_s2, 16'b0} + {16'b0, plo_s2};

	for (genvar gl = 0; gl < 3; gl++) begin : g_inc
		assign inc[gl] = qneg_q[gl] ? -$signed({2'b0, quo_q[gl]})
			: $signed({2'b0, quo_q[gl]});
	end
	assign div_busy = p_vld_q || vld_s1 || vld_s2;

	// blend: pitch first (gyro y), then roll (gyro x)
	assign a_cl    = (alpha_q15 > ALPHA_ONE[15:0] && alpha_q15[15]) ? ALPHA_ONE
		: {1'b0, alpha_q15};
	assign b_w     = ALPHA_ONE - a_cl;
	assign old_sel = (k_q == 2'd0) ? pitch_q : roll_q;
	assign acc_sel = (k_q == 2'd0) ? pacc_q : racc_q;
	assign inc_sel = (k_q == 2'd0) ? inc[1] : inc[0];
	assign sum_old = $signed({old_sel[AW-1], old_sel})
		+ $signed({{(33-INC_W){inc_sel[INC_W-1]}}, inc_sel});
	assign s_sum   = $signed({prod1_s1[50], prod1_s1}) + $signed({prod2_s2[50], prod2_s2})
		+ BLEND_RND;
	assign s_sh    = s_sum[51:15];
	always_comb begin
		if (s_sh[36:31] == 6'b000000 || s_sh[36:31] == 6'b111111) begin
			blend_sat = s_sh[31:0];
		end else if (s_sh[36]) begin
			blend_sat = {1'b1, {(AW-1){1'b0}}};
		end else begin
			blend_sat = {1'b0, {(AW-1){1'b1}}};
		end
	end

	// centidegrees, truncated toward zero
	always_comb begin
		case (k_q)
			2'd0:    ang_sel = pitch_q;
			2'd1:    ang_sel = roll_q;
			default: ang_sel = yaw_q;
		endcase
	end
	assign c_adj = cprod_q + (cprod_q[39] ? TRUNC_ADJ : 40'sd0);
	assign c_div = c_adj[39:16];
	always_comb begin
		if (c_div[23:15] == 9'h000 || c_div[23:15] == 9'h1ff) begin
			c_sat = c_div[15:0];
		end else if (c_div[23]) begin
			c_sat = 16'sh8000;
		end else begin
			c_sat = 16'sh7fff;
		end
	end

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE:  if (fe.valid) st_n = ST_GMUL;
			ST_GMUL:  if (k_q == 2'd2) st_n = ST_RGO;
			ST_RGO:   st_n = ST_RWAIT;
			ST_RWAIT: if (cr.done) st_n = ST_MAG;
			ST_MAG:   st_n = ST_PGO;
			ST_PGO:   st_n = ST_PWAIT;
			ST_PWAIT: if (cr.done) st_n = ST_DWAIT;
			ST_DWAIT: if (!div_busy) st_n = ST_BL1;
			ST_BL1:   st_n = ST_BL2;
			ST_BL2:   st_n = ST_BL3;
			ST_BL3:   st_n = (k_q == 2'd0) ? ST_BL1 : ST_YAW;
			ST_YAW:   st_n = ST_CV1;
			ST_CV1:   st_n = ST_CV2;
			ST_CV2:   st_n = (k_q == 2'd2) ? ST_OUT : ST_CV1;
			ST_OUT:   if (out_load) st_n = ST_IDLE;
			default:  st_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			k_q       <= 2'd0;
			p_vld_q   <= 1'b0;
			p_lane_q  <= 2'd0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			pitch_q   <= '0;
			roll_q    <= '0;
			yaw_q     <= '0;
		end else begin
			st_q     <= st_n;
			p_vld_q  <= (st_q == ST_GMUL);
			p_lane_q <= k_q;
			vld_s1   <= p_vld_q;
			vld_s2   <= vld_s1;
			case (st_q)
				ST_IDLE:  k_q <= 2'd0;
				ST_GMUL:  k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				ST_BL3:   k_q <= (k_q == 2'd0) ? 2'd1 : 2'd0;
				ST_CV2:   k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				default:  k_q <= k_q;
			endcase
			if (st_q == ST_BL3) begin
				if (k_q == 2'd0) pitch_q <= blend_sat;
				else roll_q <= blend_sat;
			end
			if (st_q == ST_YAW) begin
				yaw_q <= yaw_q + $signed({{(AW-INC_W){inc[2][INC_W-1]}}, inc[2]});
			end
			if (out_load) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) smp_q <= fe.smp;
		if (st_q == ST_GMUL) p_q <= p_next;
		if (p_vld_q) begin
			n_s1    <= n_load;
			neg_s1  <= p_q[40];
			lane_s1 <= p_lane_q;
		end
		if (vld_s1) begin
			plo_s2  <= n_s1[15:0] * RECIP_131;
			phi_s2  <= n_s1[DIV_W-1:16] * RECIP_131;
			neg_s2  <= neg_s1;
			lane_s2 <= lane_s1;
		end
		if (vld_s2) begin
			quo_q[lane_s2]  <= q_full[64:40];
			qneg_q[lane_s2] <= neg_s2;
		end
		if (st_q == ST_RWAIT && cr.done) racc_q <= cr.z;
		if (st_q == ST_PWAIT && cr.done) pacc_q <= cr.z;
		if (st_q == ST_MAG) mprod_q <= cr.mag[31:0] * INVK_Q30;
		if (st_q == ST_BL1) prod1_s1 <= $signed({1'b0, a_cl}) * sum_old;
		if (st_q == ST_BL2) prod2_s2 <= $signed({1'b0, b_w}) * acc_sel;
		if (st_q == ST_CV1) cprod_q <= ang_sel * CENTI;
		if (st_q == ST_CV2) res_q[k_q] <= c_sat;
		if (out_load) out_q <= {res_q[2], res_q[1], res_q[0]};
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	`ICF_ASSERT(a_cordic_free, cq.start |-> !cr.busy, "cordic started while busy")
	`ICF_ASSERT(a_cordic_done_waited, cr.done |-> (st_q == ST_RWAIT || st_q == ST_PWAIT), "cordic result with nobody waiting")
	`ICF_ASSERT(a_blend_after_div, st_q == ST_BL1 |-> !div_busy, "blend before gyro increments are ready")
	`ICF_NEVER(a_div_lane_range, vld_s2 && lane_s2 == 2'd3, "divider lane out of range")
	`ICF_NEVER(a_lane_range, k_q == 2'd3, "lane index out of range")

endmodule

// File: rtl/imu_complementary_filter.sv
// imu complementary filter: pitch, roll and yaw from raw accel and gyro samples
// the roll pass and then the pitch pass run on the shared iterative cordic; a zero accel vector
// skips its pass; one item at a time, so the back end takes the next queued beat only after
// the last result is loaded into the output register
// asynchronous active-low reset clears angles to zero, alpha to 0.98 and dt to 0.01 s
// depends on icf_pkg, icf_front, icf_cordic and icf_back
module imu_complementary_filter import icf_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // pitch_centideg, roll_centideg, yaw_centideg
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [24:0] cfg_data
);

	logic [15:0] alpha_q;
	logic [24:0] dt_q;
	fe_item_t    fe;
	logic        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 16'd32113;
			dt_q    <= 25'd167772;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data[15:0];
				REG_DT:    dt_q    <= cfg_data;
			endcase
		end
	end

	icf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.pop      (pop),
		.fe       (fe)
	);

	icf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fe        (fe),
		.pop       (pop),
		.alpha_q15 (alpha_q),
		.dt_q24    (dt_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
